@@ rtl/snep_put_request_receiver_assert.svh @@
// assertion macros shared by the receiver modules
// each one samples on clk and is off while rst_n is low
`ifndef SNEP_PUT_REQUEST_RECEIVER_ASSERT_SVH
`define SNEP_PUT_REQUEST_RECEIVER_ASSERT_SVH

// expression holds at every edge
`define SNEP_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("snep assertion failed");

// consequent holds in the same cycle as the antecedent
`define SNEP_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snep assertion failed");

// consequent holds in the cycle after the antecedent
`define SNEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snep assertion failed");

`endif

@@ rtl/snep_pkg.sv @@
package snep_pkg;

    localparam int MAX_FRAGMENT_BYTES = 4096;
    localparam int LEN_W = 12;
    // largest length the 12-bit field can carry after the fragment limit
    localparam int LEN_LIMIT_INT = (MAX_FRAGMENT_BYTES >= (1 << LEN_W) - 1)
                                   ? (1 << LEN_W) - 1 : MAX_FRAGMENT_BYTES;
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_LIMIT_INT);
    localparam logic [LEN_W-1:0] HEADER_BYTES = LEN_W'(6);
    localparam logic [LEN_W-1:0] HEADER_LAST = LEN_W'(5);

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam logic [3:0] SUPPORTED_MAJOR = 4'd1;
    localparam logic [7:0] REQ_GET = 8'h01;
    localparam logic [7:0] REQ_PUT = 8'h02;

    localparam logic [7:0] RSP_NONE = 8'h00;
    localparam logic [7:0] RSP_CONTINUE = 8'h80;
    localparam logic [7:0] RSP_BAD_REQUEST = 8'hC2;
    localparam logic [7:0] RSP_NOT_IMPL = 8'hE0;
    localparam logic [7:0] RSP_VERSION = 8'hE1;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_SHORT_HEADER = 3'd1;
    localparam logic [2:0] ERR_BAD_VERSION = 3'd2;
    localparam logic [2:0] ERR_GET_REFUSED = 3'd3;
    localparam logic [2:0] ERR_BAD_REQUEST = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW = 3'd5;

    typedef struct packed {
        logic             func;
        logic [7:0]       data_byte;
        logic             fragment_first;
        logic [LEN_W-1:0] fragment_length;
    } request_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       message_complete;
        logic       response_valid;
        logic [7:0] response_code;
        logic       disconnect;
        logic [2:0] error_kind;
    } result_t;

    // classified request handed from front to back
    typedef struct packed {
        logic             new_conn;
        logic [7:0]       data_byte;
        logic             first;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] len_minus_hdr;
        logic             len_short;
        logic             len_is_hdr;
    } cmd_t;

endpackage

@@ rtl/snep_front.sv @@
module snep_front (
    input  snep_pkg::request_t request,
    output snep_pkg::cmd_t     cmd
);

    logic [snep_pkg::LEN_W-1:0] len_clamped;

    always_comb
    begin
        // lengths above the fragment limit count as the limit
        len_clamped = (request.fragment_length > snep_pkg::LEN_LIMIT)
                      ? snep_pkg::LEN_LIMIT : request.fragment_length;
        cmd.new_conn      = ~request.func;
        cmd.data_byte     = request.data_byte;
        cmd.first         = request.fragment_first;
        cmd.len           = len_clamped;
        cmd.len_minus_hdr = len_clamped - snep_pkg::HEADER_BYTES;
        cmd.len_short     = len_clamped < snep_pkg::HEADER_BYTES;
        cmd.len_is_hdr    = len_clamped == snep_pkg::HEADER_BYTES;
    end

endmodule

@@ rtl/snep_cmd_queue.sv @@
module snep_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  snep_pkg::cmd_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output snep_pkg::cmd_t  rd_data,
    output logic            empty
);

    snep_pkg::cmd_t                 slot_reg [snep_pkg::CMD_DEPTH];
    logic [snep_pkg::CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [snep_pkg::CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [snep_pkg::CMD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           do_wr, do_rd;

    assign full    = cnt_reg == snep_pkg::CMD_CNT_W'(snep_pkg::CMD_DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;

    // pointer wrap at any depth
    function automatic logic [snep_pkg::CMD_PTR_W-1:0] ptr_inc(
        input logic [snep_pkg::CMD_PTR_W-1:0] p
    );
        ptr_inc = (p == snep_pkg::CMD_PTR_W'(snep_pkg::CMD_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

`include "snep_put_request_receiver_assert.svh"

    `SNEP_ASSERT_ALWAYS(a_cmd_cnt_bound, cnt_reg <= snep_pkg::CMD_CNT_W'(snep_pkg::CMD_DEPTH))
    `SNEP_ASSERT_IMPLIES(a_cmd_empty_ptrs, empty, wr_ptr_reg == rd_ptr_reg)
    `SNEP_ASSERT_NEXT(a_cmd_fill, do_wr && !do_rd, cnt_reg == $past(cnt_reg) + 1'b1)

endmodule

@@ rtl/snep_back.sv @@
module snep_back (
    input  logic              clk,
    input  logic              rst_n,
    input  snep_pkg::cmd_t    cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    output snep_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CLOSED  = 2'd2;

    localparam logic [1:0] RES_DEPTH = 2'd2;

    logic [1:0]                 phase_reg, phase_next;
    logic [snep_pkg::LEN_W-1:0] frag_pos_reg, frag_pos_next;
    logic                       in_first_reg, in_first_next;
    logic [3:0]                 version_reg, version_next;
    logic [7:0]                 request_reg, request_next;
    logic [31:0]                declared_reg, declared_next;
    logic [31:0]                received_reg, received_next;

    snep_pkg::result_t          res_slot_reg [2];
    logic                       res_wr_ptr_reg, res_rd_ptr_reg;
    logic [1:0]                 res_cnt_reg, res_cnt_next;
    logic                       res_pop;

    snep_pkg::result_t          res;
    logic [snep_pkg::LEN_W-1:0] idx, idx_inc;
    logic                       in_range;
    logic [31:0]                decl_shift;
    logic                       overrun;
    logic                       in_first_eff;
    logic                       done;

    assign cmd_pop = ~cmd_empty & (res_cnt_reg != RES_DEPTH);
    assign empty   = res_cnt_reg == 2'd0;
    assign result  = res_slot_reg[res_rd_ptr_reg];
    assign res_pop = pop & ~empty;

    always_comb
    begin
        phase_next    = phase_reg;
        frag_pos_next = frag_pos_reg;
        in_first_next = in_first_reg;
        version_next  = version_reg;
        request_next  = request_reg;
        declared_next = declared_reg;
        received_next = received_reg;
        res           = '0;

        idx          = cmd.first ? '0 : frag_pos_reg;
        idx_inc      = idx + 1'b1;
        in_range     = idx < cmd.len;
        decl_shift   = {declared_reg[23:0], cmd.data_byte};
        overrun      = ({1'b0, received_reg} + 33'(cmd.len)) > {1'b0, declared_reg};
        in_first_eff = in_first_reg & ~cmd.first;
        // count after this byte reaches the declared length
        done         = (received_reg >= declared_reg) || (received_reg + 1'b1 == declared_reg);

        if (cmd.new_conn)
        begin
            phase_next    = PH_HEADER;
            frag_pos_next = '0;
            in_first_next = 1'b1;
            version_next  = '0;
            request_next  = '0;
            declared_next = '0;
            received_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (idx == '0 && cmd.len_short)
                    begin
                        res.disconnect = 1'b1;
                        res.error_kind = snep_pkg::ERR_SHORT_HEADER;
                        phase_next     = PH_CLOSED;
                    end
                    else if (in_range && idx <= snep_pkg::HEADER_LAST)
                    begin
                        frag_pos_next = idx_inc;
                        case (idx)
                            snep_pkg::LEN_W'(0):
                            begin
                                version_next  = cmd.data_byte[7:4];
                                declared_next = '0;
                            end
                            snep_pkg::LEN_W'(1):
                            begin
                                request_next = cmd.data_byte;
                            end
                            default:
                            begin
                                declared_next = decl_shift;
                            end
                        endcase
                        if (idx == snep_pkg::HEADER_LAST)
                        begin
                            if (version_reg != snep_pkg::SUPPORTED_MAJOR)
                            begin
                                res.response_valid = 1'b1;
                                res.response_code  = snep_pkg::RSP_VERSION;
                                res.disconnect     = 1'b1;
                                res.error_kind     = snep_pkg::ERR_BAD_VERSION;
                                phase_next         = PH_CLOSED;
                            end
                            else if (request_reg == snep_pkg::REQ_GET)
                            begin
                                res.response_valid = 1'b1;
                                res.response_code  = snep_pkg::RSP_NOT_IMPL;
                                res.disconnect     = 1'b1;
                                res.error_kind     = snep_pkg::ERR_GET_REFUSED;
                                phase_next         = PH_CLOSED;
                            end
                            else if (request_reg != snep_pkg::REQ_PUT)
                            begin
                                res.response_valid = 1'b1;
                                res.response_code  = snep_pkg::RSP_BAD_REQUEST;
                                res.disconnect     = 1'b1;
                                res.error_kind     = snep_pkg::ERR_BAD_REQUEST;
                                phase_next         = PH_CLOSED;
                            end
                            else if (32'(cmd.len_minus_hdr) > decl_shift)
                            begin
                                res.disconnect = 1'b1;
                                res.error_kind = snep_pkg::ERR_OVERFLOW;
                                phase_next     = PH_CLOSED;
                            end
                            else
                            begin
                                received_next = '0;
                                phase_next    = PH_PAYLOAD;
                                if (cmd.len_is_hdr)
                                begin
                                    if (decl_shift == '0)
                                    begin
                                        res.message_complete = 1'b1;
                                        res.disconnect       = 1'b1;
                                        phase_next           = PH_CLOSED;
                                    end
                                    else
                                    begin
                                        res.response_valid = 1'b1;
                                        res.response_code  = snep_pkg::RSP_CONTINUE;
                                        in_first_next      = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (cmd.first)
                    begin
                        in_first_next = 1'b0;
                    end
                    if (cmd.first && overrun)
                    begin
                        res.disconnect = 1'b1;
                        res.error_kind = snep_pkg::ERR_OVERFLOW;
                        phase_next     = PH_CLOSED;
                    end
                    else if (in_range)
                    begin
                        frag_pos_next     = idx_inc;
                        res.payload_valid = 1'b1;
                        res.payload_byte  = cmd.data_byte;
                        if (received_reg < declared_reg)
                        begin
                            received_next = received_reg + 1'b1;
                        end
                        if (done)
                        begin
                            res.message_complete = 1'b1;
                            res.disconnect       = 1'b1;
                            phase_next           = PH_CLOSED;
                        end
                        else if (in_first_eff && idx_inc == cmd.len)
                        begin
                            res.response_valid = 1'b1;
                            res.response_code  = snep_pkg::RSP_CONTINUE;
                            in_first_next      = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // closed: bytes ignored until a new connection
                end
            endcase
        end
    end

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (cmd_pop && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + 1'b1;
        end
        else if (res_pop && !cmd_pop)
        begin
            res_cnt_next = res_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            frag_pos_reg   <= '0;
            in_first_reg   <= 1'b1;
            version_reg    <= '0;
            request_reg    <= '0;
            declared_reg   <= '0;
            received_reg   <= '0;
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (cmd_pop)
            begin
                phase_reg      <= phase_next;
                frag_pos_reg   <= frag_pos_next;
                in_first_reg   <= in_first_next;
                version_reg    <= version_next;
                request_reg    <= request_next;
                declared_reg   <= declared_next;
                received_reg   <= received_next;
                res_wr_ptr_reg <= ~res_wr_ptr_reg;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= ~res_rd_ptr_reg;
            end
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            res_slot_reg[res_wr_ptr_reg] <= res;
        end
    end

`include "snep_put_request_receiver_assert.svh"

    `SNEP_ASSERT_ALWAYS(a_res_cnt_bound, res_cnt_reg <= RES_DEPTH)
    `SNEP_ASSERT_IMPLIES(a_complete_closes, cmd_pop && res.message_complete, res.disconnect)
    `SNEP_ASSERT_IMPLIES(a_continue_keeps_open, cmd_pop && res.response_code == snep_pkg::RSP_CONTINUE, !res.disconnect)
    `SNEP_ASSERT_NEXT(a_disconnect_closes, cmd_pop && res.disconnect, phase_reg == PH_CLOSED)

endmodule

@@ rtl/snep_put_request_receiver.sv @@
// channel   | handshake             | payload
// ----------+-----------------------+-------------------------------
// request   | push / full           | request (snep_pkg::request_t)
// result    | empty / pop           | result  (snep_pkg::result_t)
//
// one result per request, one request per cycle sustained while pop keeps the result queue from filling
// a taken request is registered in the request queue, then processed and registered in the result queue
// the back end's per-connection state update (one byte a cycle) sets the rate
// rst_n clears both queues and restarts in the awaiting-header phase
// a stalled result side fills a two-entry result queue and then the
// two-entry request queue, after which full rises
module snep_put_request_receiver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  snep_pkg::request_t request,
    output logic               empty,
    input  logic               pop,
    output snep_pkg::result_t  result
);

    // classified request from the front end
    snep_pkg::cmd_t front_cmd;
    // head of the request queue as seen by the back end
    snep_pkg::cmd_t back_cmd;
    logic           cmd_empty;
    logic           cmd_pop;

    // front: clamp the fragment length and precompute the length checks
    snep_front u_front (
        .request (request),
        .cmd     (front_cmd)
    );

    // short queue that decouples intake from execution
    snep_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    // back: header parse, length tracking, responses, result queue
    snep_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
